// ===== rtl/windowed_peak_current_meter_macros.svh =====
// Assertion macros used by the RTL module windowed_peak_current_meter.sv.
`ifndef WINDOWED_PEAK_CURRENT_METER_MACROS_SVH
`define WINDOWED_PEAK_CURRENT_METER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WPCM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WPCM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/wpcm_pkg.sv =====
package wpcm_pkg;

  localparam int CODE_W = 10;
  localparam int TICK_W = 16;
  localparam int MA_W   = 15;
  localparam int MAG_W  = 13;
  localparam int TEN_W  = 14;
  localparam int CONV_W = 32;
  localparam int PROD_W = MAG_W + CONV_W;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic [TICK_W-1:0] WINDOW_RESET = 16'd500;
  localparam logic [TICK_W-1:0] TICK_MAX     = 16'hFFFF;
  localparam logic [TEN_W-1:0]  CODE_OFFSET  = 14'd5115;
  // Fractional part of the code-to-milliamp factor in Q32; the integer part is one.
  localparam logic [CONV_W-1:0] CONV_FRAC    = 32'd3126832557;
  localparam logic signed [MA_W-1:0] MA_LIMIT = 15'sd8839;

  typedef enum logic {
    ACT_SAMPLE = 1'b0,
    ACT_TICK   = 1'b1
  } action_t;

  typedef enum logic {
    REG_WINDOW = 1'b0,
    REG_NONE   = 1'b1
  } reg_idx_t;

  typedef struct packed {
    action_t             action;
    logic [CODE_W-1:0]   sample;
  } in_item_t;

  typedef struct packed {
    logic signed [MA_W-1:0] current_ma;
    logic [CODE_W-1:0]      filtered_code;
  } out_item_t;

endpackage

// ===== rtl/windowed_peak_current_meter.sv =====
// Channel | Direction | Handshake            | Request payload
// in_     | input     | in_valid / in_stall   | in_item_t: action, sample
// out_    | output    | out_valid / out_stall | out_item_t: current_ma, filtered_code
// cfg     | APB       | psel / penable        | window_ticks at byte address 0
//
// One request is taken every cycle while in_stall is low; peak, window and counter state settle in that cycle.
// A reading passes the s1, s2 and output registers in turn after its sample request.
// The conversion multiply and the rounding add each have a pipeline stage of their own.
// Reset is synchronous on rst_n and clears all control state and the window to 500.
// in_stall rises only when all three result stages hold readings and out_stall is high.

`include "windowed_peak_current_meter_macros.svh"

module windowed_peak_current_meter
  import wpcm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [TICK_W-1:0] window_r, window_nxt;
  logic [CODE_W-1:0] peak_r, peak_nxt;
  logic [CODE_W-1:0] prev_r, prev_nxt;
  logic [TICK_W-1:0] tick_r, tick_nxt;

  logic              s1_v_r, s1_v_nxt;
  logic [CODE_W-1:0] s1_filt_r;
  logic              s2_v_r, s2_v_nxt;
  logic [PROD_W-1:0] s2_prod_r;
  logic [MAG_W-1:0]  s2_mag_r;
  logic              s2_neg_r;
  logic [CODE_W-1:0] s2_filt_r;
  logic              out_v_r, out_v_nxt;
  out_item_t         out_data_r;

  reg_idx_t          reg_idx;
  logic              cfg_wr;
  logic              in_acc;
  logic              fire;
  logic [CODE_W-1:0] peak_upd;
  logic [CODE_W:0]   blend_sum;
  logic [CODE_W-1:0] filt;
  logic              out_ready, s2_ready, s1_ready;
  logic [TEN_W-1:0]  s1_ten;
  logic              s1_neg;
  logic [MAG_W-1:0]  s1_mag;
  logic [PROD_W:0]   rnd_sum;
  logic [MAG_W:0]    frac_ma;
  logic [MAG_W:0]    mag_ma;
  logic [MA_W-1:0]   ma_val;

  assign reg_idx = reg_idx_t'(paddr[ADDR_W-1]);
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign prdata  = (reg_idx == REG_WINDOW) ? {{(DATA_W-TICK_W){1'b0}}, window_r} : '0;

  assign out_ready = !out_v_r || !out_stall;
  assign s2_ready  = !s2_v_r || out_ready;
  assign s1_ready  = !s1_v_r || s2_ready;
  assign in_stall  = !s1_ready;
  assign in_acc    = in_valid && !in_stall;

  assign peak_upd  = (in_data.sample > peak_r)
                   ? CODE_W'(({1'b0, peak_r} + {1'b0, in_data.sample}) >> 1) : peak_r;
  assign fire      = in_acc && (in_data.action == ACT_SAMPLE) && (tick_r >= window_r);
  assign blend_sum = {1'b0, prev_r} + {1'b0, peak_upd};
  assign filt      = blend_sum[CODE_W:1];

  always_comb begin
    window_nxt = window_r;
    peak_nxt   = peak_r;
    prev_nxt   = prev_r;
    tick_nxt   = tick_r;
    if (cfg_wr && (reg_idx == REG_WINDOW)) begin
      window_nxt = pwdata[TICK_W-1:0];
    end
    if (in_acc) begin
      case (in_data.action)
        ACT_TICK: begin
          if (tick_r != TICK_MAX) begin
            tick_nxt = tick_r + 1'b1;
          end
        end
        ACT_SAMPLE: begin
          if (fire) begin
            peak_nxt = '0;
            prev_nxt = filt;
            tick_nxt = '0;
          end else begin
            peak_nxt = peak_upd;
          end
        end
        default: begin
          tick_nxt = tick_r;
        end
      endcase
    end
  end

  always_comb begin
    s1_v_nxt  = fire || (s1_v_r && !s2_ready);
    s2_v_nxt  = (s1_v_r && s2_ready) || (s2_v_r && !out_ready);
    out_v_nxt = (s2_v_r && out_ready) || (out_v_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WINDOW_RESET;
      peak_r   <= '0;
      prev_r   <= '0;
      tick_r   <= '0;
      s1_v_r   <= 1'b0;
      s2_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      window_r <= window_nxt;
      peak_r   <= peak_nxt;
      prev_r   <= prev_nxt;
      tick_r   <= tick_nxt;
      s1_v_r   <= s1_v_nxt;
      s2_v_r   <= s2_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  // The reading is (10 * code - 5115) times the conversion factor, rounded to nearest.
  assign s1_ten = ({4'b0, s1_filt_r} << 3) + ({4'b0, s1_filt_r} << 1);
  assign s1_neg = s1_ten < CODE_OFFSET;
  assign s1_mag = s1_neg ? MAG_W'(CODE_OFFSET - s1_ten) : MAG_W'(s1_ten - CODE_OFFSET);

  assign rnd_sum = {1'b0, s2_prod_r} + (PROD_W+1)'(64'h8000_0000);
  assign frac_ma = (MAG_W+1)'(rnd_sum >> CONV_W);
  assign mag_ma  = {1'b0, s2_mag_r} + frac_ma;
  assign ma_val  = s2_neg_r ? MA_W'(-{1'b0, mag_ma}) : MA_W'({1'b0, mag_ma});

  always_ff @(posedge clk) begin
    if (fire && s1_ready) begin
      s1_filt_r <= filt;
    end
    if (s1_v_r && s2_ready) begin
      s2_prod_r <= {{CONV_W{1'b0}}, s1_mag} * {{MAG_W{1'b0}}, CONV_FRAC};
      s2_mag_r  <= s1_mag;
      s2_neg_r  <= s1_neg;
      s2_filt_r <= s1_filt_r;
    end
    if (s2_v_r && out_ready) begin
      out_data_r.current_ma    <= ma_val;
      out_data_r.filtered_code <= s2_filt_r;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_data_r;

  `WPCM_ASSERT_NOW(a_stall_full, in_stall, s1_v_r && s2_v_r && out_v_r && out_stall, "input stalled with room in the pipeline")
  `WPCM_ASSERT_NEXT(a_tick_keeps_peak, in_acc && (in_data.action == ACT_TICK), $stable(peak_r) && $stable(prev_r), "tick changed the peak or previous code")
  `WPCM_ASSERT_NEXT(a_fire_clears, fire, (peak_r == '0) && (tick_r == '0) && s1_v_r, "reading did not clear the window state")
  `WPCM_ASSERT_NOW(a_ma_range, out_v_r, (out_data_r.current_ma <= MA_LIMIT) && (out_data_r.current_ma >= -MA_LIMIT), "current reading out of range")

endmodule
